// ===== rtl/afld_pkg.sv =====
// Shared types, constants and code-conversion functions of the AF list decoder.
// No dependencies; the RTL files refer to it by scoped names, the testbench imports it.
`timescale 1ns / 1ps
`default_nettype none

package afld_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int FREQ_W      = 12;
  localparam int KEY_W       = FREQ_W + 1;
  localparam int CODE_W      = 8;
  localparam int LEFT_W      = 5;

  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] REG_TUNED_BAND  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TUNED_VALUE = 1'd1;

  // Block kinds
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_NEXT  = 1'b1;

  // Bands
  localparam logic BAND_UHF  = 1'b0;
  localparam logic BAND_LFMF = 1'b1;

  // Special codes
  localparam logic [CODE_W-1:0] CODE_MAX_FREQ = 8'd204;
  localparam logic [CODE_W-1:0] CODE_LFMF     = 8'd250;
  localparam logic [CODE_W-1:0] MF_FIRST_CODE = 8'd16;

  // Frequency conversion
  localparam logic [FREQ_W-1:0] FREQ_UHF_BASE = 12'd876;
  localparam logic [FREQ_W-1:0] FREQ_LF_BASE  = 12'd153;
  localparam logic [FREQ_W-1:0] FREQ_MF_BASE  = 12'd531;
  localparam logic [FREQ_W-1:0] FREQ_STEP     = 12'd9;

  typedef enum logic [1:0] {
    METH_UNKNOWN = 2'd0,
    METH_A       = 2'd1,
    METH_B       = 2'd2
  } method_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ISSUE,
    ST_WAIT,
    ST_EMIT
  } state_e;

  // Key: band on top, frequency value below
  typedef logic [KEY_W-1:0] key_t;

  // Candidate travelling along the cell row
  typedef struct packed {
    logic             vld;
    logic             done;
    logic             stored;
    logic [CNT_W-1:0] pos;
    logic [IDX_W-1:0] slot;
    key_t             key;
    logic             attrib;
  } tok_t;

  function automatic logic is_freq(input logic [CODE_W-1:0] code);
    return (code != '0) && (code <= CODE_MAX_FREQ);
  endfunction

  function automatic logic [FREQ_W-1:0] code_freq(input logic [CODE_W-1:0] code,
                                                 input logic band);
    logic [FREQ_W-1:0] c12;
    c12 = {{(FREQ_W-CODE_W){1'b0}}, code};
    if (!is_freq(code)) begin
      return '0;
    end else if (band == BAND_UHF) begin
      return FREQ_UHF_BASE + c12 - 12'd1;
    end else if (code < MF_FIRST_CODE) begin
      return FREQ_LF_BASE + FREQ_STEP * (c12 - 12'd1);
    end else begin
      return FREQ_MF_BASE + FREQ_STEP * (c12 - {{(FREQ_W-CODE_W){1'b0}}, MF_FIRST_CODE});
    end
  endfunction

  // LF/MF sorts below UHF, same band by value
  function automatic logic key_lt(input key_t a, input key_t b);
    if (a[KEY_W-1] == b[KEY_W-1]) begin
      return a[FREQ_W-1:0] < b[FREQ_W-1:0];
    end else begin
      return (a[KEY_W-1] == BAND_LFMF) && (b[KEY_W-1] == BAND_UHF);
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/afld_blk_if.sv =====
// Input channel: one received block (start or following) per beat.
// Depends on afld_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface afld_blk_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [afld_pkg::LEFT_W-1:0]   freq_count;
  logic [afld_pkg::CODE_W-1:0]   first_code;
  logic [afld_pkg::CODE_W-1:0]   second_code;

  modport source (output valid, req_type, freq_count, first_code, second_code,
                  input ready);
  modport sink   (input valid, req_type, freq_count, first_code, second_code,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/afld_res_if.sv =====
// Result channel: one inserted entry, or one status-only beat, per beat.
// Depends on afld_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface afld_res_if;
  logic                          valid;
  logic                          ready;
  logic                          entry_valid;
  logic [4:0]                    entry_index;
  logic                          entry_band;
  logic [afld_pkg::FREQ_W-1:0]   entry_freq;
  logic                          entry_attrib;
  logic [5:0]                    table_count;
  logic [1:0]                    coding_method;
  logic [afld_pkg::LEFT_W-1:0]   codes_remaining;
  logic                          last;

  modport source (output valid, entry_valid, entry_index, entry_band, entry_freq,
                  entry_attrib, table_count, coding_method, codes_remaining, last,
                  input ready);
  modport sink   (input valid, entry_valid, entry_index, entry_band, entry_freq,
                  entry_attrib, table_count, coding_method, codes_remaining, last,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/afld_cell.sv =====
// One table cell: holds one entry and passes the travelling candidate on.
// Depends on afld_pkg (tok_t, widths).
`timescale 1ns / 1ps
`default_nettype none

module afld_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  afld_pkg::tok_t              tok_i,
  input  logic [afld_pkg::CNT_W-1:0]  total_i,
  output afld_pkg::tok_t              tok_o
);

  afld_pkg::key_t key_q;
  afld_pkg::tok_t tok_d;
  afld_pkg::tok_t tok_q;
  logic           occupied;
  logic           store;

  // Match against a filled entry, or claim the first empty one
  always_comb begin
    tok_d    = tok_i;
    store    = 1'b0;
    occupied = (tok_i.pos < total_i);
    if (tok_i.vld && !tok_i.done) begin
      if (occupied) begin
        if (key_q == tok_i.key) begin
          tok_d.done = 1'b1;
        end
      end else begin
        store        = 1'b1;
        tok_d.done   = 1'b1;
        tok_d.stored = 1'b1;
        tok_d.slot   = tok_i.pos[afld_pkg::IDX_W-1:0];
      end
    end
    tok_d.pos = tok_i.pos + afld_pkg::CNT_ONE;
  end

  // Advance the candidate one cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  // Hold the entry once written
  always_ff @(posedge clk_i) begin
    if (store) begin
      key_q <= tok_i.key;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

// ===== rtl/afld_ctrl.sv =====
// Sequencer: decodes a block into up to three insert candidates, sends them
// one by one down the cell row, collects the outcomes and emits the results.
// Depends on afld_pkg, afld_blk_if and afld_res_if.
`timescale 1ns / 1ps
`default_nettype none

module afld_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [afld_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [afld_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  afld_blk_if.sink                         blk_i,
  afld_res_if.source                       res_o,
  output afld_pkg::tok_t                   head_o,
  input  afld_pkg::tok_t                   tail_i,
  output logic [afld_pkg::CNT_W-1:0]       total_o
);

  typedef struct packed {
    afld_pkg::key_t key;
    logic           attrib;
  } cand_t;

  typedef struct packed {
    logic [afld_pkg::IDX_W-1:0] slot;
    afld_pkg::key_t             key;
    logic                       attrib;
  } rec_t;

  afld_pkg::state_e state_q, state_d;

  // Block held for decoding
  logic                          req_q;
  logic [afld_pkg::LEFT_W-1:0]   cnt_q;
  logic [afld_pkg::CODE_W-1:0]   c1_q;
  logic [afld_pkg::CODE_W-1:0]   c2_q;

  // Decoder state
  logic [afld_pkg::LEFT_W-1:0]   left_q, left_d;
  logic                          band_q, band_d;
  afld_pkg::method_e             mnow_q, mnow_d;
  afld_pkg::method_e             mprev_q, mprev_d;
  afld_pkg::key_t                held_q, held_d;
  logic                          tuned_band_q;
  logic [afld_pkg::FREQ_W-1:0]   tuned_value_q;
  logic [afld_pkg::CNT_W-1:0]    total_q;

  // Candidates and collected results
  cand_t                         cand_q [3];
  cand_t                         cand_d [3];
  logic [1:0]                    cand_n_q, cand_n_d;
  logic [1:0]                    idx_q;
  rec_t                          res_q [3];
  logic [1:0]                    res_n_q;
  logic [1:0]                    emit_idx_q;
  logic                          emit_last;
  rec_t                          emit_rec;

  function automatic logic [afld_pkg::LEFT_W-1:0] dec_sat(
      input logic [afld_pkg::LEFT_W-1:0] v);
    return (v != '0) ? v - 5'd1 : v;
  endfunction

  // Decode the held block into new state and a candidate list
  always_comb begin
    logic [afld_pkg::LEFT_W-1:0] left1;
    logic                        band1;
    logic                        h1;
    logic                        h2;
    afld_pkg::key_t              k1;
    afld_pkg::key_t              k2;
    afld_pkg::method_e           m;
    logic                        go;
    logic                        lt;
    left_d   = left_q;
    band_d   = band_q;
    mnow_d   = mnow_q;
    mprev_d  = mprev_q;
    held_d   = held_q;
    cand_n_d = 2'd0;
    for (int i = 0; i < 3; i++) begin
      cand_d[i] = '0;
    end
    left1 = '0;
    band1 = afld_pkg::BAND_UHF;
    h1    = 1'b1;
    h2    = 1'b1;
    k1    = '0;
    k2    = '0;
    m     = mnow_q;
    go    = 1'b0;
    lt    = 1'b0;
    if (req_q == afld_pkg::REQ_START) begin
      // Open a list: one code, band back to UHF unless it switches to LF/MF, restore the learned method
      if (mprev_q != afld_pkg::METH_UNKNOWN) begin
        mnow_d = mprev_q;
      end
      left_d = dec_sat(cnt_q);
      band_d = (c2_q == afld_pkg::CODE_LFMF) ? afld_pkg::BAND_LFMF : afld_pkg::BAND_UHF;
      if (afld_pkg::is_freq(c2_q)) begin
        cand_d[0] = '{key: {afld_pkg::BAND_UHF,
                            afld_pkg::code_freq(c2_q, afld_pkg::BAND_UHF)},
                      attrib: 1'b0};
        cand_n_d  = 2'd1;
      end
    end else if (left_q != '0) begin
      // Following block: two codes, each may switch to LF/MF
      left1  = left_q - 5'd1;
      band1  = (c1_q == afld_pkg::CODE_LFMF) ? afld_pkg::BAND_LFMF : band_q;
      h1     = !afld_pkg::is_freq(c1_q);
      k1     = {band1, afld_pkg::code_freq(c1_q, band1)};
      left_d = dec_sat(left1);
      band_d = (c2_q == afld_pkg::CODE_LFMF) ? afld_pkg::BAND_LFMF : band1;
      h2     = !afld_pkg::is_freq(c2_q);
      k2     = {band_d, afld_pkg::code_freq(c2_q, band_d)};
      go     = 1'b1;
      // Learn the method from the first block that carries a frequency
      if (mnow_q == afld_pkg::METH_UNKNOWN) begin
        if (h1 && h2) begin
          go = 1'b0;
        end else if (h1 || h2) begin
          m = afld_pkg::METH_A;
        end else if ((k1 == held_q) || (k2 == held_q)) begin
          m = afld_pkg::METH_B;
        end else begin
          m = afld_pkg::METH_A;
          if (held_q[afld_pkg::FREQ_W-1:0] != '0) begin
            cand_d[cand_n_d] = '{key: held_q, attrib: 1'b0};
            cand_n_d         = cand_n_d + 2'd1;
            held_d           = '0;
          end
        end
      end
      if (go) begin
        mnow_d  = m;
        mprev_d = m;
        if (m == afld_pkg::METH_A) begin
          if (!h1) begin
            cand_d[cand_n_d] = '{key: k1, attrib: 1'b0};
            cand_n_d         = cand_n_d + 2'd1;
          end
          if (!h2) begin
            cand_d[cand_n_d] = '{key: k2, attrib: 1'b0};
            cand_n_d         = cand_n_d + 2'd1;
          end
        end else if (!h1 && !h2) begin
          // Method B: keep the partner of the tuned frequency
          lt = afld_pkg::key_lt(k1, k2);
          if (held_q == k1) begin
            cand_d[cand_n_d] = '{key: k2, attrib: lt};
            cand_n_d         = cand_n_d + 2'd1;
          end else if (held_q == k2) begin
            cand_d[cand_n_d] = '{key: k1, attrib: lt};
            cand_n_d         = cand_n_d + 2'd1;
          end
        end
      end
    end
  end

  assign emit_last = (res_n_q == 2'd0) || ((emit_idx_q + 2'd1) == res_n_q);
  assign emit_rec  = res_q[emit_idx_q];

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= afld_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and handshake outputs
  always_comb begin
    state_d     = state_q;
    blk_i.ready = 1'b0;
    res_o.valid = 1'b0;
    head_o      = '0;
    case (state_q)
      afld_pkg::ST_IDLE: begin
        blk_i.ready = 1'b1;
        if (blk_i.valid) begin
          state_d = afld_pkg::ST_DECODE;
        end
      end
      afld_pkg::ST_DECODE: begin
        state_d = (cand_n_d == 2'd0) ? afld_pkg::ST_EMIT : afld_pkg::ST_ISSUE;
      end
      afld_pkg::ST_ISSUE: begin
        head_o.vld    = 1'b1;
        head_o.key    = cand_q[idx_q].key;
        head_o.attrib = cand_q[idx_q].attrib;
        state_d       = afld_pkg::ST_WAIT;
      end
      afld_pkg::ST_WAIT: begin
        if (tail_i.vld) begin
          state_d = ((idx_q + 2'd1) == cand_n_q) ? afld_pkg::ST_EMIT : afld_pkg::ST_ISSUE;
        end
      end
      afld_pkg::ST_EMIT: begin
        res_o.valid = 1'b1;
        if (res_o.ready && emit_last) begin
          state_d = afld_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = afld_pkg::ST_IDLE;
      end
    endcase
  end

  // Control and decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q        <= '0;
      band_q        <= afld_pkg::BAND_UHF;
      mnow_q        <= afld_pkg::METH_UNKNOWN;
      mprev_q       <= afld_pkg::METH_UNKNOWN;
      held_q        <= '0;
      tuned_band_q  <= 1'b0;
      tuned_value_q <= '0;
      total_q       <= '0;
      cand_n_q      <= 2'd0;
      idx_q         <= 2'd0;
      res_n_q       <= 2'd0;
      emit_idx_q    <= 2'd0;
    end else begin
      if (cfg_we_i) begin
        // Each write refreshes the held copy of the tuned frequency
        case (cfg_idx_i)
          afld_pkg::REG_TUNED_BAND: begin
            tuned_band_q <= cfg_data_i[0];
            held_q       <= {cfg_data_i[0], tuned_value_q};
          end
          afld_pkg::REG_TUNED_VALUE: begin
            tuned_value_q <= cfg_data_i;
            held_q        <= {tuned_band_q, cfg_data_i};
          end
          default: begin
            tuned_band_q <= tuned_band_q;
          end
        endcase
      end else if (state_q == afld_pkg::ST_DECODE) begin
        held_q <= held_d;
      end
      case (state_q)
        afld_pkg::ST_DECODE: begin
          left_q     <= left_d;
          band_q     <= band_d;
          mnow_q     <= mnow_d;
          mprev_q    <= mprev_d;
          cand_n_q   <= cand_n_d;
          idx_q      <= 2'd0;
          res_n_q    <= 2'd0;
          emit_idx_q <= 2'd0;
        end
        afld_pkg::ST_WAIT: begin
          if (tail_i.vld) begin
            idx_q <= idx_q + 2'd1;
            if (tail_i.stored) begin
              total_q <= total_q + afld_pkg::CNT_ONE;
              res_n_q <= res_n_q + 2'd1;
            end
          end
        end
        afld_pkg::ST_EMIT: begin
          if (res_o.ready) begin
            emit_idx_q <= emit_idx_q + 2'd1;
          end
        end
        default: begin
          idx_q <= idx_q;
        end
      endcase
    end
  end

  // Payload: block, candidates and result records
  always_ff @(posedge clk_i) begin
    if (blk_i.valid && blk_i.ready) begin
      req_q <= blk_i.req_type;
      cnt_q <= blk_i.freq_count;
      c1_q  <= blk_i.first_code;
      c2_q  <= blk_i.second_code;
    end
    if (state_q == afld_pkg::ST_DECODE) begin
      cand_q <= cand_d;
    end
    if ((state_q == afld_pkg::ST_WAIT) && tail_i.vld && tail_i.stored) begin
      res_q[res_n_q] <= '{slot: tail_i.slot, key: tail_i.key, attrib: tail_i.attrib};
    end
  end

  // Result beat: inserted entry or a status-only beat
  always_comb begin
    res_o.entry_valid     = (res_n_q != 2'd0);
    res_o.entry_index     = '0;
    res_o.entry_band      = 1'b0;
    res_o.entry_freq      = '0;
    res_o.entry_attrib    = 1'b0;
    if (res_n_q != 2'd0) begin
      res_o.entry_index  = 5'(emit_rec.slot);
      res_o.entry_band   = emit_rec.key[afld_pkg::KEY_W-1];
      res_o.entry_freq   = emit_rec.key[afld_pkg::FREQ_W-1:0];
      res_o.entry_attrib = emit_rec.attrib;
    end
    res_o.table_count     = 6'(total_q);
    res_o.coding_method   = mnow_q;
    res_o.codes_remaining = left_q;
    res_o.last            = emit_last;
  end

  assign total_o = total_q;

endmodule

`default_nettype wire

// ===== rtl/rds_af_list_decoder.sv =====
// Alternative-frequency list decoder, top level: sequencer plus a row of
// TABLE_DEPTH table cells that a candidate entry walks through.
// A block is decoded into zero to three insert candidates, each issued in turn and walked
// through the 32-cell row; results then follow one a cycle while res_o.ready is high.
// A new block is accepted only after the last result of the previous one is taken.
// Reset: async active low; clears counts, method and tuned copy; cell contents stay undefined.
`timescale 1ns / 1ps
`default_nettype none

module rds_af_list_decoder (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [afld_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [afld_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  afld_blk_if.sink                         blk_i,
  afld_res_if.source                       res_o
);

  afld_pkg::tok_t               chain [afld_pkg::TABLE_DEPTH + 1];
  logic [afld_pkg::CNT_W-1:0]   total;

  afld_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .blk_i      (blk_i),
    .res_o      (res_o),
    .head_o     (chain[0]),
    .tail_i     (chain[afld_pkg::TABLE_DEPTH]),
    .total_o    (total)
  );

  // Row of table cells, candidate handed on every cycle
  for (genvar g = 0; g < afld_pkg::TABLE_DEPTH; g++) begin : g_cell
    afld_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .tok_i   (chain[g]),
      .total_i (total),
      .tok_o   (chain[g + 1])
    );
  end

endmodule

`default_nettype wire

// ===== verif/rds_af_list_decoder_tb.sv =====
// Testbench for the AF list decoder: directed table, then random AF lists per tuning phase.
// Depends on afld_pkg, afld_blk_if, afld_res_if and rds_af_list_decoder.
`timescale 1ns / 1ps

module rds_af_list_decoder_tb;
  import afld_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 120;
  localparam int ITEMS_PER_PHASE = 26;

  // One result beat as the decoder reports it
  typedef struct packed {
    logic        ev;
    logic [4:0]  idx;
    logic        band;
    logic [11:0] freq;
    logic        attrib;
    logic [5:0]  tcount;
    logic [1:0]  meth;
    logic [4:0]  left;
    logic        last;
  } af_report_t;

  // Directed row: a tuning write or one block, optionally with a fixed report
  typedef struct {
    bit          is_cfg;
    logic        band;
    logic [11:0] value;
    logic        rt;
    logic [4:0]  cnt;
    logic [7:0]  c1;
    logic [7:0]  c2;
    bit          typed;
    af_report_t  fix;
  } dir_row_t;

  typedef struct {
    logic        band;
    logic [11:0] value;
    logic [7:0]  code;   // code that hits the tuned frequency, 0 if none
  } tuning_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  afld_blk_if blk ();
  afld_res_if res ();

  rds_af_list_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .blk_i      (blk),
    .res_o      (res)
  );

  // Predicted decoder state
  logic [13:0] af_table [TABLE_DEPTH];
  int          table_fill;
  logic [4:0]  left_cnt;
  logic        cur_band;
  method_e     meth_now;
  method_e     meth_prev;
  logic [12:0] held_key;
  logic        tune_band;
  logic [11:0] tune_value;

  af_report_t block_reports[$];
  af_report_t af_reports_due[$];

  int fail_cnt;
  int src_idle_pct;
  int snk_stall_pct;
  int hold_asked;
  int hold_taken;
  int hold_cnt;
  int cycle_cnt;

  // Frequency key of a code in the given band: band on top, value below
  function automatic logic [12:0] code_key(input logic [7:0] code, input logic band);
    int c;
    int f;
    c = code;
    if (code == 8'd0 || code > CODE_MAX_FREQ) f = 0;
    else if (band == BAND_UHF) f = FREQ_UHF_BASE + c - 1;
    else if (code < MF_FIRST_CODE) f = FREQ_LF_BASE + FREQ_STEP * (c - 1);
    else f = FREQ_MF_BASE + FREQ_STEP * (c - MF_FIRST_CODE);
    return {band, f[11:0]};
  endfunction

  // LF/MF ranks below UHF; within a band compare values
  function automatic bit key_less(input logic [12:0] a, input logic [12:0] b);
    if (a[12] == b[12]) return a[11:0] < b[11:0];
    return (a[12] == BAND_LFMF) && (b[12] == BAND_UHF);
  endfunction

  // Count the code down, follow a band switch; true when it is no frequency
  function automatic bit drop_code(input logic [7:0] code);
    if (left_cnt != 5'd0) left_cnt--;
    if (code == CODE_LFMF) cur_band = BAND_LFMF;
    return !(code != 8'd0 && code <= CODE_MAX_FREQ);
  endfunction

  // Insert unless full or already held; log the insert
  function automatic void table_insert(input logic [12:0] key, input logic attrib);
    int i;
    if (table_fill >= TABLE_DEPTH) return;
    for (i = 0; i < table_fill; i++)
      if (af_table[i][12:0] == key) return;
    af_table[table_fill] = {attrib, key};
    block_reports.push_back('{1'b1, 5'(table_fill), key[12], key[11:0], attrib,
                              6'd0, METH_UNKNOWN, 5'd0, 1'b0});
    table_fill++;
  endfunction

  // Work out the reports of one accepted block into block_reports
  function automatic void decode_af_block(input logic rt, input logic [4:0] cnt,
                                          input logic [7:0] c1, input logic [7:0] c2);
    bit h1;
    bit h2;
    bit no_pair;
    logic [12:0] k1;
    logic [12:0] k2;
    int n;
    block_reports.delete();
    no_pair = 1'b0;
    if (rt == REQ_START) begin
      left_cnt = cnt;
      cur_band = BAND_UHF;
      if (meth_prev != METH_UNKNOWN) meth_now = meth_prev;
      if (!drop_code(c2)) table_insert(code_key(c2, cur_band), 1'b0);
    end else if (left_cnt != 5'd0) begin
      h1 = drop_code(c1);
      k1 = code_key(c1, cur_band);
      h2 = drop_code(c2);
      k2 = code_key(c2, cur_band);
      // learn the coding method from the first pair carrying a frequency
      if (meth_now == METH_UNKNOWN) begin
        if (h1 && h2) begin
          no_pair = 1'b1;
        end else if (h1 || h2) begin
          meth_now = METH_A;
        end else if (k1 == held_key || k2 == held_key) begin
          meth_now = METH_B;
        end else begin
          meth_now = METH_A;
          if (held_key[11:0] != 12'd0) begin
            table_insert(held_key, 1'b0);
            held_key = '0;
          end
        end
      end
      if (!no_pair) begin
        meth_prev = meth_now;
        if (meth_now == METH_A) begin
          if (!h1) table_insert(k1, 1'b0);
          if (!h2) table_insert(k2, 1'b0);
        end else if (!h1 && !h2) begin
          if (held_key == k1) table_insert(k2, key_less(k1, k2));
          else if (held_key == k2) table_insert(k1, key_less(k1, k2));
        end
      end
    end
    if (block_reports.size() == 0) block_reports.push_back('0);
    n = block_reports.size();
    foreach (block_reports[k]) begin
      block_reports[k].tcount = table_fill[5:0];
      block_reports[k].meth = meth_now;
      block_reports[k].left = left_cnt;
      block_reports[k].last = (k == n - 1);
    end
  endfunction

  function automatic dir_row_t blk_row(input logic rt, input logic [4:0] cnt,
                                       input logic [7:0] a, input logic [7:0] b);
    dir_row_t r;
    r = '{1'b0, BAND_UHF, 12'd0, rt, cnt, a, b, 1'b0, '0};
    return r;
  endfunction

  function automatic dir_row_t fix_row(input logic rt, input logic [4:0] cnt,
                                       input logic [7:0] a, input logic [7:0] b,
                                       input af_report_t want);
    dir_row_t r;
    r = blk_row(rt, cnt, a, b);
    r.typed = 1'b1;
    r.fix = want;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic band, input logic [11:0] value);
    dir_row_t r;
    r = blk_row(REQ_START, 5'd0, 8'd0, 8'd0);
    r.is_cfg = 1'b1;
    r.band = band;
    r.value = value;
    return r;
  endfunction

  // Frequency code, mostly from a narrow pool so duplicates turn up
  function automatic logic [7:0] pick_freq_code();
    if ($urandom_range(1) != 0) return 8'($urandom_range(24, 1));
    return 8'($urandom_range(204, 1));
  endfunction

  function automatic void cmp_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      fail_cnt++;
    end
  endfunction

  // Offer one block, hold it until taken, then queue its reports
  task automatic send_block(input logic rt, input logic [4:0] cnt, input logic [7:0] a,
                            input logic [7:0] b, input bit typed, input af_report_t fix);
    while ($urandom_range(99) < src_idle_pct) begin
      blk.valid <= 1'b0;
      @(posedge clk_i);
    end
    blk.valid <= 1'b1;
    blk.req_type <= rt;
    blk.freq_count <= cnt;
    blk.first_code <= a;
    blk.second_code <= b;
    @(posedge clk_i);
    while (!blk.ready) @(posedge clk_i);
    decode_af_block(rt, cnt, a, b);
    if (typed) af_reports_due.push_back(fix);
    else foreach (block_reports[k]) af_reports_due.push_back(block_reports[k]);
  endtask

  // Write both tuning registers once every report is in
  task automatic write_tuning(input logic band, input logic [11:0] value);
    blk.valid <= 1'b0;
    while (af_reports_due.size() != 0) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_TUNED_BAND;
    cfg_data_i <= {{(CFG_DATA_W-1){1'b0}}, band};
    @(posedge clk_i);
    tune_band = band;
    held_key = {tune_band, tune_value};
    cfg_idx_i <= REG_TUNED_VALUE;
    cfg_data_i <= value;
    @(posedge clk_i);
    tune_value = value;
    held_key = {tune_band, tune_value};
    cfg_we_i <= 1'b0;
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Result side: check each beat, stall at random, honour hold-off requests
  always @(posedge clk_i) begin
    af_report_t got;
    af_report_t want;
    if (rst_ni) begin
      if (res.valid && res.ready) begin
        got = '{res.entry_valid, res.entry_index, res.entry_band, res.entry_freq,
                res.entry_attrib, res.table_count, res.coding_method, res.codes_remaining,
                res.last};
        if (af_reports_due.size() == 0) begin
          $display("%0t: unexpected report, expected none actual %h", $time, got);
          fail_cnt++;
        end else begin
          want = af_reports_due.pop_front();
          cmp_field("entry_valid", want.ev, got.ev);
          cmp_field("entry_index", want.idx, got.idx);
          cmp_field("entry_band", want.band, got.band);
          cmp_field("entry_freq", want.freq, got.freq);
          cmp_field("entry_attrib", want.attrib, got.attrib);
          cmp_field("table_count", want.tcount, got.tcount);
          cmp_field("coding_method", want.meth, got.meth);
          cmp_field("codes_remaining", want.left, got.left);
          cmp_field("last", want.last, got.last);
        end
      end
      if (hold_cnt == 0 && hold_taken != hold_asked) begin
        hold_taken = hold_asked;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt != 0) begin
        hold_cnt--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end else begin
      res.ready <= 1'b0;
    end
  end

  // Watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Stimulus
  initial begin
    dir_row_t dir_tab[$];
    tuning_t tunings[8];
    tuning_t tn;
    int ph;
    int pick;
    logic rt;
    logic [4:0] cnt;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] tmp;

    rst_ni = 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= REG_TUNED_BAND;
    cfg_data_i <= '0;
    blk.valid <= 1'b0;
    blk.req_type <= REQ_START;
    blk.freq_count <= '0;
    blk.first_code <= '0;
    blk.second_code <= '0;

    table_fill = 0;
    left_cnt = '0;
    cur_band = BAND_UHF;
    meth_now = METH_UNKNOWN;
    meth_prev = METH_UNKNOWN;
    held_key = '0;
    tune_band = BAND_UHF;
    tune_value = '0;
    fail_cnt = 0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    hold_asked = 0;
    hold_taken = 0;
    hold_cnt = 0;

    // Directed: empty list, fillers, band switch, extremes, method B learning and pairs
    dir_tab.push_back(fix_row(REQ_NEXT, 5'd25, 8'd0, 8'd0,
      '{1'b0, 5'd0, BAND_UHF, 12'd0, 1'b0, 6'd0, METH_UNKNOWN, 5'd0, 1'b1}));
    dir_tab.push_back(fix_row(REQ_START, 5'd0, 8'hFF, 8'd0,
      '{1'b0, 5'd0, BAND_UHF, 12'd0, 1'b0, 6'd0, METH_UNKNOWN, 5'd0, 1'b1}));
    dir_tab.push_back(fix_row(REQ_START, 5'd25, 8'd0, 8'd1,
      '{1'b1, 5'd0, BAND_UHF, 12'd876, 1'b0, 6'd1, METH_UNKNOWN, 5'd24, 1'b1}));
    dir_tab.push_back(fix_row(REQ_NEXT, 5'd6, 8'd0, 8'd205,
      '{1'b0, 5'd0, BAND_UHF, 12'd0, 1'b0, 6'd1, METH_UNKNOWN, 5'd22, 1'b1}));
    dir_tab.push_back(blk_row(REQ_NEXT, 5'd0, 8'd255, CODE_LFMF));
    dir_tab.push_back(fix_row(REQ_START, 5'd25, 8'd0, CODE_MAX_FREQ,
      '{1'b1, 5'd1, BAND_UHF, 12'd1079, 1'b0, 6'd2, METH_UNKNOWN, 5'd24, 1'b1}));
    dir_tab.push_back(fix_row(REQ_START, 5'd3, 8'd0, CODE_LFMF,
      '{1'b0, 5'd0, BAND_UHF, 12'd0, 1'b0, 6'd2, METH_UNKNOWN, 5'd2, 1'b1}));
    dir_tab.push_back(cfg_row(BAND_UHF, 12'd1000));
    dir_tab.push_back(blk_row(REQ_START, 5'd25, 8'd0, 8'd2));
    dir_tab.push_back(blk_row(REQ_NEXT, 5'd0, 8'd125, 8'd130));
    dir_tab.push_back(blk_row(REQ_NEXT, 5'd0, 8'd140, 8'd125));
    dir_tab.push_back(blk_row(REQ_NEXT, 5'd0, 8'd125, 8'd130));
    dir_tab.push_back(blk_row(REQ_NEXT, 5'd0, 8'd125, 8'd0));
    dir_tab.push_back(blk_row(REQ_NEXT, 5'd0, 8'd3, 8'd4));
    dir_tab.push_back(blk_row(REQ_NEXT, 5'd0, CODE_LFMF, 8'd125));
    dir_tab.push_back(cfg_row(BAND_LFMF, 12'd2223));
    dir_tab.push_back(blk_row(REQ_START, 5'd25, 8'd0, CODE_LFMF));
    dir_tab.push_back(blk_row(REQ_NEXT, 5'd0, CODE_MAX_FREQ, 8'd1));
    dir_tab.push_back(blk_row(REQ_NEXT, 5'd0, 8'd15, CODE_MAX_FREQ));
    dir_tab.push_back(blk_row(REQ_NEXT, 5'd0, MF_FIRST_CODE, CODE_MAX_FREQ));
    dir_tab.push_back(blk_row(REQ_START, 5'd1, 8'd0, CODE_LFMF));
    dir_tab.push_back(blk_row(REQ_NEXT, 5'd0, CODE_MAX_FREQ, MF_FIRST_CODE));
    dir_tab.push_back(blk_row(REQ_START, 5'd2, 8'd0, CODE_MAX_FREQ));
    dir_tab.push_back(blk_row(REQ_NEXT, 5'd0, 8'd205, 8'd205));

    // Tuning per random phase, with the code that hits it where one exists
    tunings[0] = '{BAND_UHF, 12'd1000, 8'd125};
    tunings[1] = '{BAND_LFMF, 12'd2223, 8'd204};
    tunings[2] = '{BAND_UHF, 12'd1079, 8'd204};
    tunings[3] = '{BAND_LFMF, 12'd153, 8'd1};
    tunings[4] = '{BAND_UHF, 12'd876, 8'd1};
    tunings[5] = '{BAND_LFMF, 12'd531, 8'd16};
    tunings[6] = '{BAND_UHF, 12'd0, 8'd0};
    tunings[7] = '{BAND_LFMF, 12'd1500, 8'd0};

    // Reset
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg)
        write_tuning(dir_tab[i].band, dir_tab[i].value);
      else
        send_block(dir_tab[i].rt, dir_tab[i].cnt, dir_tab[i].c1, dir_tab[i].c2,
                   dir_tab[i].typed, dir_tab[i].fix);
    end

    // Random lists: mostly tuned/partner pairs, some foreign pairs and raw noise
    for (ph = 0; ph < 8; ph++) begin
      tn = tunings[ph];
      write_tuning(tn.band, tn.value);
      case (ph % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 84; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 84; end
        default: begin src_idle_pct = 16; snk_stall_pct = 16; end
      endcase
      if (ph % 4 == 0) hold_asked++;
      repeat (ITEMS_PER_PHASE) begin
        cnt = 5'($urandom_range(25));
        a = 8'($urandom_range(255));
        b = 8'($urandom_range(255));
        if (left_cnt == 5'd0 && $urandom_range(9) != 0) begin
          rt = REQ_START;
          pick = $urandom_range(9);
          if (tn.band == BAND_LFMF && pick < 7) b = CODE_LFMF;
          else if (pick < 8) b = pick_freq_code();
        end else begin
          rt = REQ_NEXT;
          pick = $urandom_range(99);
          if (pick < 70 && tn.code != 8'd0) begin
            a = tn.code;
            b = pick_freq_code();
            if ($urandom_range(1) != 0) begin
              tmp = a;
              a = b;
              b = tmp;
            end
          end else if (pick < 85) begin
            a = pick_freq_code();
            b = pick_freq_code();
          end
        end
        send_block(rt, cnt, a, b, 1'b0, '0);
      end
    end

    // Drain
    blk.valid <= 1'b0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    while (af_reports_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/afld_pkg.sv
rtl/afld_blk_if.sv
rtl/afld_res_if.sv
rtl/afld_cell.sv
rtl/afld_ctrl.sv
rtl/rds_af_list_decoder.sv
verif/rds_af_list_decoder_tb.sv
